@@ hw/rtl/arcade_main_bus_decoder_core_assert.svh @@
// Assertion macros used by the checker file of the bus decoder.
`ifndef ARCADE_MAIN_BUS_DECODER_CORE_ASSERT_SVH
`define ARCADE_MAIN_BUS_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AMB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/amb_pkg.sv @@
package amb_pkg;

    localparam int WORK_DEPTH   = 4096;
    localparam int VIDEO_DEPTH  = 3072;
    localparam int SPRITE_DEPTH = 128;
    localparam int RAM_AW       = 12;
    localparam int SPRITE_AW    = 7;
    localparam int CFG_IDX_W    = 1;

    // Request types.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 1'b1;

    // Address map.
    localparam logic [15:0] SPRITE_BASE   = 16'hCC00;
    localparam logic [15:0] SPRITE_END    = 16'hCC80;
    localparam logic [15:0] VIDEO_BASE    = 16'hD000;
    localparam logic [15:0] VIDEO_END     = 16'hDC00;
    localparam logic [15:0] WORK_BASE     = 16'hE000;
    localparam logic [15:0] WORK_END      = 16'hF000;
    localparam logic [15:0] BANKED_BASE   = 16'h8000;
    localparam logic [15:0] IO_BASE       = 16'hC000;
    localparam logic [15:0] SYS_ADDR      = 16'hC000;
    localparam logic [15:0] P1_ADDR       = 16'hC001;
    localparam logic [15:0] P2_ADDR       = 16'hC002;
    localparam logic [15:0] DIP_A_ADDR    = 16'hC003;
    localparam logic [15:0] DIP_B_ADDR    = 16'hC004;
    localparam logic [15:0] SOUND_ADDR    = 16'hC800;
    localparam logic [15:0] SCROLL_LO_ADDR = 16'hC802;
    localparam logic [15:0] SCROLL_HI_ADDR = 16'hC803;
    localparam logic [15:0] SRESET_ADDR   = 16'hC804;
    localparam logic [15:0] PALETTE_ADDR  = 16'hC805;
    localparam logic [15:0] BANK_ADDR     = 16'hC806;

    localparam logic [7:0] SRESET_MASK = 8'h10;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;
    localparam logic [7:0] DIP_RESET   = 8'hFF;

    typedef enum logic [3:0] {
        SRC_ROM, SRC_SPRITE, SRC_VIDEO, SRC_WORK, SRC_SYS,
        SRC_P1, SRC_P2, SRC_DIP_A, SRC_DIP_B, SRC_OPEN
    } src_t;

    typedef enum logic [3:0] {
        TGT_NONE, TGT_SPRITE, TGT_VIDEO, TGT_WORK, TGT_SOUND,
        TGT_SCROLL_LO, TGT_SCROLL_HI, TGT_SRESET, TGT_PALETTE, TGT_BANK
    } tgt_t;

    typedef struct packed {
        src_t src;
        tgt_t tgt;
        logic banked;
    } dec_t;

    typedef struct packed {
        logic              active;
        logic [RAM_AW-1:0] addr;
    } clr_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
        logic [7:0]  system_port;
        logic [7:0]  player_one_port;
        logic [7:0]  player_two_port;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_read;
        logic [16:0] rom_address;
        logic [7:0]  sound_command_out;
        logic [15:0] scroll_out;
        logic [1:0]  palette_bank_out;
        logic [1:0]  rom_bank_out;
        logic        sound_reset_out;
    } res_t;

endpackage

@@ hw/rtl/arcade_main_bus_decoder_core.sv @@
// A transaction accepted at one clock edge shows its result, marked by done, during
// the next cycle; while busy is low, throughput is one transaction per cycle, limited
// by the one port of each internal RAM. The receiver cannot stall the result.
// Reset: asynchronous, active low. After reset busy stays high while the work,
// video and sprite RAMs are swept to zero; configuration writes are taken.
module arcade_main_bus_decoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  amb_pkg::req_t                     req,
    output logic                              done,
    output amb_pkg::res_t                     result,
    input  logic                              cfg_we,
    input  logic [amb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);

    localparam logic [amb_pkg::RAM_AW-1:0] VIDEO_LIMIT  = amb_pkg::RAM_AW'(amb_pkg::VIDEO_DEPTH);
    localparam logic [amb_pkg::RAM_AW-1:0] SPRITE_LIMIT = amb_pkg::RAM_AW'(amb_pkg::SPRITE_DEPTH);

    // Where the read byte of the pending result comes from.
    typedef enum logic [1:0] {SEL_IMM, SEL_SPRITE, SEL_VIDEO, SEL_WORK} sel_t;

    amb_pkg::clr_t clr;
    amb_pkg::dec_t dec;

    logic accept;
    logic is_read;
    logic is_write;

    logic [amb_pkg::RAM_AW-1:0]    ram_addr;
    logic [amb_pkg::SPRITE_AW-1:0] sprite_addr;
    logic [7:0]                    ram_wdata;
    logic                          work_we;
    logic                          video_we;
    logic                          sprite_we;
    logic [7:0]                    work_q;
    logic [7:0]                    video_q;
    logic [7:0]                    sprite_q;

    // Control registers written by the CPU and by the configuration port.
    logic [7:0]  sound_reg,   sound_next;
    logic [15:0] scroll_reg,  scroll_next;
    logic [1:0]  palette_reg, palette_next;
    logic [1:0]  bank_reg,    bank_next;
    logic        sreset_reg,  sreset_next;
    logic [7:0]  dip_a_reg,   dip_a_next;
    logic [7:0]  dip_b_reg,   dip_b_next;

    // Result stage.
    logic        done_reg,     done_next;
    sel_t        sel_reg,      sel_next;
    logic [7:0]  imm_reg,      imm_next;
    logic        rom_read_reg, rom_read_next;
    logic [16:0] rom_addr_reg, rom_addr_next;

    amb_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr)
    );

    amb_decode u_decode (
        .addr (req.bus_address),
        .dec  (dec)
    );

    // The block only refuses transactions while the RAMs are being cleared.
    assign busy     = clr.active;
    assign accept   = start && !busy;
    assign is_read  = accept && (req.req_type == amb_pkg::REQ_READ);
    assign is_write = accept && (req.req_type == amb_pkg::REQ_WRITE);

    // The clearing sweep owns the RAM ports; afterwards the CPU address drives them.
    // A read is issued at the accepting edge and its data appears in the next cycle,
    // which is exactly when the result is shown. A write in one cycle is visible to
    // a read accepted in the next, so no forwarding is needed.
    assign ram_addr    = clr.active ? clr.addr : req.bus_address[amb_pkg::RAM_AW-1:0];
    assign sprite_addr = clr.active ? clr.addr[amb_pkg::SPRITE_AW-1:0]
                                    : req.bus_address[amb_pkg::SPRITE_AW-1:0];
    assign ram_wdata   = clr.active ? 8'h00 : req.write_value;
    assign work_we     = clr.active || (is_write && dec.tgt == amb_pkg::TGT_WORK);
    assign video_we    = (clr.active && clr.addr < VIDEO_LIMIT)
                      || (is_write && dec.tgt == amb_pkg::TGT_VIDEO);
    assign sprite_we   = (clr.active && clr.addr < SPRITE_LIMIT)
                      || (is_write && dec.tgt == amb_pkg::TGT_SPRITE);

    amb_ram #(.WIDTH(8), .DEPTH(4096)) u_work_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (work_we),
        .wdata (ram_wdata),
        .rdata (work_q)
    );

    amb_ram #(.WIDTH(8), .DEPTH(3072)) u_video_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (video_we),
        .wdata (ram_wdata),
        .rdata (video_q)
    );

    amb_ram #(.WIDTH(8), .DEPTH(128)) u_sprite_ram (
        .clk   (clk),
        .addr  (sprite_addr),
        .we    (sprite_we),
        .wdata (ram_wdata),
        .rdata (sprite_q)
    );

    // Control register updates. A frame start drops the sticky sound reset request;
    // writes to ROM or unmapped addresses fall through untouched.
    always_comb
    begin
        sound_next   = sound_reg;
        scroll_next  = scroll_reg;
        palette_next = palette_reg;
        bank_next    = bank_reg;
        sreset_next  = sreset_reg;
        dip_a_next   = dip_a_reg;
        dip_b_next   = dip_b_reg;

        if (is_write)
        begin
            case (dec.tgt)
                amb_pkg::TGT_SOUND:     sound_next = req.write_value;
                amb_pkg::TGT_SCROLL_LO: scroll_next = {scroll_reg[15:8], req.write_value};
                amb_pkg::TGT_SCROLL_HI: scroll_next = {req.write_value, scroll_reg[7:0]};
                amb_pkg::TGT_SRESET:
                begin
                    if ((req.write_value & amb_pkg::SRESET_MASK) != 8'h00)
                    begin
                        sreset_next = 1'b1;
                    end
                end
                amb_pkg::TGT_PALETTE:   palette_next = req.write_value[1:0];
                amb_pkg::TGT_BANK:      bank_next = req.write_value[1:0];
                default:                sound_next = sound_reg;
            endcase
        end
        else if (accept && req.req_type == amb_pkg::REQ_FRAME)
        begin
            sreset_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                amb_pkg::CFG_DIP_A: dip_a_next = cfg_data;
                amb_pkg::CFG_DIP_B: dip_b_next = cfg_data;
                default:            dip_a_next = dip_a_reg;
            endcase
        end
    end

    // Result capture. Port and switch bytes are latched at acceptance, since the
    // request fields are gone by the time the result is shown; RAM bytes come
    // straight from the registered RAM outputs.
    always_comb
    begin
        done_next     = accept;
        sel_next      = sel_reg;
        imm_next      = imm_reg;
        rom_read_next = rom_read_reg;
        rom_addr_next = rom_addr_reg;

        if (accept)
        begin
            sel_next      = SEL_IMM;
            imm_next      = 8'h00;
            rom_read_next = 1'b0;
            rom_addr_next = '0;
        end

        if (is_read)
        begin
            case (dec.src)
                amb_pkg::SRC_ROM:
                begin
                    rom_read_next = 1'b1;
                    if (dec.banked)
                    begin
                        rom_addr_next = {1'b0, bank_reg, 14'd0} + {1'b0, req.bus_address};
                    end
                    else
                    begin
                        rom_addr_next = {1'b0, req.bus_address};
                    end
                end
                amb_pkg::SRC_SPRITE: sel_next = SEL_SPRITE;
                amb_pkg::SRC_VIDEO:  sel_next = SEL_VIDEO;
                amb_pkg::SRC_WORK:   sel_next = SEL_WORK;
                amb_pkg::SRC_SYS:    imm_next = req.system_port;
                amb_pkg::SRC_P1:     imm_next = req.player_one_port;
                amb_pkg::SRC_P2:     imm_next = req.player_two_port;
                amb_pkg::SRC_DIP_A:  imm_next = dip_a_reg;
                amb_pkg::SRC_DIP_B:  imm_next = dip_b_reg;
                default:             imm_next = amb_pkg::OPEN_BUS;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_reg   <= '0;
            scroll_reg  <= '0;
            palette_reg <= '0;
            bank_reg    <= '0;
            sreset_reg  <= 1'b0;
            dip_a_reg   <= amb_pkg::DIP_RESET;
            dip_b_reg   <= amb_pkg::DIP_RESET;
            done_reg    <= 1'b0;
            sel_reg     <= SEL_IMM;
        end
        else
        begin
            sound_reg   <= sound_next;
            scroll_reg  <= scroll_next;
            palette_reg <= palette_next;
            bank_reg    <= bank_next;
            sreset_reg  <= sreset_next;
            dip_a_reg   <= dip_a_next;
            dip_b_reg   <= dip_b_next;
            done_reg    <= done_next;
            sel_reg     <= sel_next;
        end
    end

    // Payload of the result stage needs no reset; it is only looked at with done.
    always_ff @(posedge clk)
    begin
        imm_reg      <= imm_next;
        rom_read_reg <= rom_read_next;
        rom_addr_reg <= rom_addr_next;
    end

    always_comb
    begin
        case (sel_reg)
            SEL_SPRITE: result.read_data = sprite_q;
            SEL_VIDEO:  result.read_data = video_q;
            SEL_WORK:   result.read_data = work_q;
            default:    result.read_data = imm_reg;
        endcase
    end

    // The control fields show the state as it stands after the transaction.
    assign result.rom_read          = rom_read_reg;
    assign result.rom_address       = rom_addr_reg;
    assign result.sound_command_out = sound_reg;
    assign result.scroll_out        = scroll_reg;
    assign result.palette_bank_out  = palette_reg;
    assign result.rom_bank_out      = bank_reg;
    assign result.sound_reset_out   = sreset_reg;
    assign done                     = done_reg;

endmodule

@@ hw/rtl/amb_ram.sv @@
module amb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/amb_clear.sv @@
module amb_clear (
    input  logic          clk,
    input  logic          rst_n,
    output amb_pkg::clr_t clr
);

    localparam logic [amb_pkg::RAM_AW-1:0] LAST = amb_pkg::RAM_AW'(amb_pkg::WORK_DEPTH - 1);

    logic                       active_reg;
    logic [amb_pkg::RAM_AW-1:0] cnt_reg;

    // Sweeps every RAM address once after reset, writing zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign clr.active = active_reg;
    assign clr.addr   = cnt_reg;

endmodule

@@ hw/rtl/amb_decode.sv @@
module amb_decode (
    input  logic [15:0]   addr,
    output amb_pkg::dec_t dec
);

    always_comb
    begin
        dec.src    = amb_pkg::SRC_OPEN;
        dec.tgt    = amb_pkg::TGT_NONE;
        dec.banked = (addr >= amb_pkg::BANKED_BASE) && (addr < amb_pkg::IO_BASE);

        if (addr < amb_pkg::IO_BASE)
        begin
            dec.src = amb_pkg::SRC_ROM;
        end
        else if (addr >= amb_pkg::SPRITE_BASE && addr < amb_pkg::SPRITE_END)
        begin
            dec.src = amb_pkg::SRC_SPRITE;
            dec.tgt = amb_pkg::TGT_SPRITE;
        end
        else if (addr >= amb_pkg::VIDEO_BASE && addr < amb_pkg::VIDEO_END)
        begin
            dec.src = amb_pkg::SRC_VIDEO;
            dec.tgt = amb_pkg::TGT_VIDEO;
        end
        else if (addr >= amb_pkg::WORK_BASE && addr < amb_pkg::WORK_END)
        begin
            dec.src = amb_pkg::SRC_WORK;
            dec.tgt = amb_pkg::TGT_WORK;
        end
        else
        begin
            unique case (addr)
                amb_pkg::SYS_ADDR:       dec.src = amb_pkg::SRC_SYS;
                amb_pkg::P1_ADDR:        dec.src = amb_pkg::SRC_P1;
                amb_pkg::P2_ADDR:        dec.src = amb_pkg::SRC_P2;
                amb_pkg::DIP_A_ADDR:     dec.src = amb_pkg::SRC_DIP_A;
                amb_pkg::DIP_B_ADDR:     dec.src = amb_pkg::SRC_DIP_B;
                amb_pkg::SOUND_ADDR:     dec.tgt = amb_pkg::TGT_SOUND;
                amb_pkg::SCROLL_LO_ADDR: dec.tgt = amb_pkg::TGT_SCROLL_LO;
                amb_pkg::SCROLL_HI_ADDR: dec.tgt = amb_pkg::TGT_SCROLL_HI;
                amb_pkg::SRESET_ADDR:    dec.tgt = amb_pkg::TGT_SRESET;
                amb_pkg::PALETTE_ADDR:   dec.tgt = amb_pkg::TGT_PALETTE;
                amb_pkg::BANK_ADDR:      dec.tgt = amb_pkg::TGT_BANK;
                default:                 dec.src = amb_pkg::SRC_OPEN;
            endcase
        end
    end

endmodule

@@ hw/rtl/amb_check.sv @@
`include "arcade_main_bus_decoder_core_assert.svh"

module amb_check (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input amb_pkg::req_t req,
    input logic          done,
    input amb_pkg::res_t result
);

    // Every accepted transaction produces a result in the very next cycle.
    `AMB_ASSERT_NEXT(a_done_follows, start && !busy, done, "accepted transaction gave no result")

    // No result appears without a transaction accepted in the cycle before.
    `AMB_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without a transaction")

    // A ROM read leaves the data byte to external ROM.
    `AMB_ASSERT_SAME(a_rom_zero, done && result.rom_read, result.read_data == 8'h00,
        "ROM read returned internal data")

    // A frame start clears the sound reset request.
    `AMB_ASSERT_NEXT(a_frame_clear, start && !busy && req.req_type == amb_pkg::REQ_FRAME,
        !result.sound_reset_out, "frame start left sound reset set")

    // Once the RAM sweep ends, busy never returns.
    `AMB_ASSERT_NEXT(a_busy_once, !busy, !busy, "busy rose after the RAM sweep")

endmodule

bind arcade_main_bus_decoder_core amb_check u_check (.*);

@@ test/tb_arcade_main_bus_decoder_core.sv @@
module tb_arcade_main_bus_decoder_core;
    import amb_pkg::*;

    // Request code 3 is not defined by the bus; the decoder must treat it as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Generous bound on the whole run, counting the RAM sweep after reset.
    localparam int RUN_LIMIT = 200000;
    localparam int PHASE_ITEMS = 210;

    typedef struct {
        req_t rq;
        bit   pinned;
        res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    // When pin_valid is high, the transaction on req carries a hand-written
    // expectation that replaces the decoder model's answer.
    logic pin_valid;
    res_t pin_want;

    // Shadow copy of everything the decoder remembers.
    logic [7:0]  work_mem   [WORK_DEPTH];
    logic [7:0]  video_mem  [VIDEO_DEPTH];
    logic [7:0]  sprite_mem [SPRITE_DEPTH];
    logic [7:0]  sound_cmd_q;
    logic [15:0] scroll_q;
    logic [1:0]  palette_q;
    logic [1:0]  bank_q;
    logic        sound_reset_q;
    logic [7:0]  dip_a_q;
    logic [7:0]  dip_b_q;

    res_t due_answers [$];
    stim_row_t stim_table [$];
    int cycle_count = 0;
    int mismatches = 0;
    int answers_checked = 0;
    int accesses_taken = 0;

    arcade_main_bus_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Puts the shadow state into its power-on condition: RAMs cleared, latches
    // at zero and both DIP banks reading all ones.
    task automatic clear_shadow();
        for (int i = 0; i < WORK_DEPTH; i++) work_mem[i] = 8'h00;
        for (int i = 0; i < VIDEO_DEPTH; i++) video_mem[i] = 8'h00;
        for (int i = 0; i < SPRITE_DEPTH; i++) sprite_mem[i] = 8'h00;
        sound_cmd_q = 8'h00;
        scroll_q = 16'h0000;
        palette_q = 2'd0;
        bank_q = 2'd0;
        sound_reset_q = 1'b0;
        dip_a_q = DIP_RESET;
        dip_b_q = DIP_RESET;
    endtask

    // Decodes one bus access against the shadow state, applies its side
    // effects and returns the answer the decoder must give.
    task automatic decode_access(input req_t rq, output res_t rs);
        logic [15:0] a;
        a = rq.bus_address;
        rs = '0;
        case (rq.req_type)
            REQ_READ:
            begin
                if (a < BANKED_BASE)
                begin
                    // Fixed program ROM is addressed directly.
                    rs.rom_read = 1'b1;
                    rs.rom_address = {1'b0, a};
                end
                else if (a < IO_BASE)
                begin
                    // Banked window: each bank step moves the offset by 16 KiB.
                    rs.rom_read = 1'b1;
                    rs.rom_address = {1'b0, bank_q, 14'd0} + {1'b0, a};
                end
                else if (a >= SPRITE_BASE && a < SPRITE_END)
                    rs.read_data = sprite_mem[a[6:0]];
                else if (a >= VIDEO_BASE && a < VIDEO_END)
                    rs.read_data = video_mem[a[11:0]];
                else if (a >= WORK_BASE && a < WORK_END)
                    rs.read_data = work_mem[a[11:0]];
                else
                begin
                    case (a)
                        SYS_ADDR:   rs.read_data = rq.system_port;
                        P1_ADDR:    rs.read_data = rq.player_one_port;
                        P2_ADDR:    rs.read_data = rq.player_two_port;
                        DIP_A_ADDR: rs.read_data = dip_a_q;
                        DIP_B_ADDR: rs.read_data = dip_b_q;
                        default:    rs.read_data = OPEN_BUS;
                    endcase
                end
            end
            REQ_WRITE:
            begin
                if (a >= SPRITE_BASE && a < SPRITE_END)
                    sprite_mem[a[6:0]] = rq.write_value;
                else if (a >= VIDEO_BASE && a < VIDEO_END)
                    video_mem[a[11:0]] = rq.write_value;
                else if (a >= WORK_BASE && a < WORK_END)
                    work_mem[a[11:0]] = rq.write_value;
                else
                begin
                    case (a)
                        SOUND_ADDR:     sound_cmd_q = rq.write_value;
                        SCROLL_LO_ADDR: scroll_q[7:0] = rq.write_value;
                        SCROLL_HI_ADDR: scroll_q[15:8] = rq.write_value;
                        // The sound reset request is sticky: only bit 4 sets it.
                        SRESET_ADDR:
                            if ((rq.write_value & SRESET_MASK) != 8'h00)
                                sound_reset_q = 1'b1;
                        PALETTE_ADDR:   palette_q = rq.write_value[1:0];
                        BANK_ADDR:      bank_q = rq.write_value[1:0];
                        default:        ;
                    endcase
                end
            end
            REQ_FRAME:
                sound_reset_q = 1'b0;
            default:
                ;
        endcase
        rs.sound_command_out = sound_cmd_q;
        rs.scroll_out = scroll_q;
        rs.palette_bank_out = palette_q;
        rs.rom_bank_out = bank_q;
        rs.sound_reset_out = sound_reset_q;
    endtask

    task automatic compare_answer(input res_t want, input res_t got);
        if (got.read_data !== want.read_data)
        begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            mismatches++;
        end
        if (got.rom_read !== want.rom_read)
        begin
            $error("rom_read: expected %b, got %b", want.rom_read, got.rom_read);
            mismatches++;
        end
        if (got.rom_address !== want.rom_address)
        begin
            $error("rom_address: expected %h, got %h", want.rom_address, got.rom_address);
            mismatches++;
        end
        if (got.sound_command_out !== want.sound_command_out)
        begin
            $error("sound_command_out: expected %h, got %h",
                   want.sound_command_out, got.sound_command_out);
            mismatches++;
        end
        if (got.scroll_out !== want.scroll_out)
        begin
            $error("scroll_out: expected %h, got %h", want.scroll_out, got.scroll_out);
            mismatches++;
        end
        if (got.palette_bank_out !== want.palette_bank_out)
        begin
            $error("palette_bank_out: expected %h, got %h",
                   want.palette_bank_out, got.palette_bank_out);
            mismatches++;
        end
        if (got.rom_bank_out !== want.rom_bank_out)
        begin
            $error("rom_bank_out: expected %h, got %h", want.rom_bank_out, got.rom_bank_out);
            mismatches++;
        end
        if (got.sound_reset_out !== want.sound_reset_out)
        begin
            $error("sound_reset_out: expected %b, got %b",
                   want.sound_reset_out, got.sound_reset_out);
            mismatches++;
        end
    endtask

    // The monitor samples everything at the rising edge, before the edge's own
    // updates land. A result strobe is checked first; it always belongs to an
    // older transaction than one accepted at the same edge.
    always @(posedge clk)
    begin : bus_monitor
        res_t answer;
        cycle_count++;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                if (due_answers.size() == 0)
                begin
                    $error("result strobe with no transaction outstanding");
                    mismatches++;
                end
                else
                begin
                    compare_answer(due_answers.pop_front(), result);
                    answers_checked++;
                end
            end
            if (cfg_we === 1'b1)
            begin
                if (cfg_index == CFG_DIP_A)
                    dip_a_q = cfg_data;
                else if (cfg_index == CFG_DIP_B)
                    dip_b_q = cfg_data;
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                decode_access(req, answer);
                if (pin_valid)
                    answer = pin_want;
                due_answers.push_back(answer);
                accesses_taken++;
            end
        end
    end

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, due_answers.size());
        $display("** arcade_main_bus_decoder_core: FAILED **");
        $finish;
    end

    function automatic req_t bus_req(logic [1:0] kind, logic [15:0] addr, logic [7:0] wv,
                                     logic [7:0] sys, logic [7:0] p1, logic [7:0] p2);
        req_t r;
        r.req_type = kind;
        r.bus_address = addr;
        r.write_value = wv;
        r.system_port = sys;
        r.player_one_port = p1;
        r.player_two_port = p2;
        return r;
    endfunction

    // Answer while the sound, scroll, palette and sound reset latches are still
    // at their reset values.
    function automatic res_t quiet_answer(logic [7:0] data, logic rom_rd,
                                          logic [16:0] rom_addr, logic [1:0] bank);
        res_t r;
        r = '0;
        r.read_data = data;
        r.rom_read = rom_rd;
        r.rom_address = rom_addr;
        r.rom_bank_out = bank;
        return r;
    endfunction

    task automatic add_row(input req_t rq, input bit pinned, input res_t want);
        stim_row_t row;
        row.rq = rq;
        row.pinned = pinned;
        row.want = want;
        stim_table.push_back(row);
    endtask

    // Picks an address window that the decoder treats specially, with video
    // and work RAM accesses kept to small windows at each end so that reads
    // often hit bytes written earlier.
    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0: a = 16'($urandom_range(0, 16'h7FFF));
            1: a = 16'($urandom_range(16'h8000, 16'hBFFF));
            2: a = 16'(IO_BASE + $urandom_range(0, 7));
            3, 4: a = 16'(SOUND_ADDR + $urandom_range(0, 7));
            5: a = 16'(SPRITE_BASE + $urandom_range(0, 16'h8F));
            6: a = $urandom_range(0, 1) ? 16'(VIDEO_BASE + $urandom_range(0, 31))
                                        : 16'(VIDEO_END - 16 + $urandom_range(0, 31));
            7: a = $urandom_range(0, 1) ? 16'(WORK_BASE + $urandom_range(0, 31))
                                        : 16'(WORK_END - 16 + $urandom_range(0, 31));
            8: a = 16'($urandom_range(16'hC000, 16'hFFFF));
            default: a = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return a;
    endfunction

    function automatic req_t random_access();
        logic [1:0] kind;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            kind = REQ_READ;
        else if (roll < 90)
            kind = REQ_WRITE;
        else if (roll < 97)
            kind = REQ_FRAME;
        else
            kind = REQ_UNUSED;
        return bus_req(kind, pick_address(), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endfunction

    // Offers one transaction, first idling with the given chance per cycle,
    // and returns at the edge that accepts it. start is left high so that a
    // following transaction can go out back to back.
    task automatic issue(input req_t rq, input bit pinned, input res_t want, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= rq;
        pin_valid <= pinned;
        pin_want <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits for an edge before the queue is first looked at, so that a
    // transaction accepted at the current edge is counted by then.
    task automatic drain();
        do
            @(posedge clk);
        while (due_answers.size() != 0);
    endtask

    initial
    begin : stimulus
        int idle_by_phase [4];
        int directed_count;
        idle_by_phase = '{0, 60, 35, 0};
        clear_shadow();
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        pin_valid <= 1'b0;
        pin_want <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DIP_A;
        cfg_data <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The switch banks may be written while the RAM sweep is still running.
        write_register(CFG_DIP_A, DIP_RESET);
        write_register(CFG_DIP_B, DIP_RESET);

        // Directed accesses. Rows with a typed answer rely on the state right after
        // reset or on earlier typed rows; the rest are left to the decoder model.
        add_row(bus_req(REQ_READ, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1,
                quiet_answer(8'h00, 1'b1, 17'h00000, 2'd0));
        add_row(bus_req(REQ_READ, 16'h7FFF, 8'hFF, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b1, 17'h07FFF, 2'd0));
        add_row(bus_req(REQ_READ, 16'h8000, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1,
                quiet_answer(8'h00, 1'b1, 17'h08000, 2'd0));
        add_row(bus_req(REQ_READ, 16'hBFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1,
                quiet_answer(8'h00, 1'b1, 17'h0BFFF, 2'd0));
        add_row(bus_req(REQ_READ, SYS_ADDR, 8'h00, 8'h5A, 8'hFF, 8'h00), 1,
                quiet_answer(8'h5A, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, P1_ADDR, 8'h00, 8'h00, 8'hA5, 8'hFF), 1,
                quiet_answer(8'hA5, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, P2_ADDR, 8'h00, 8'hFF, 8'h00, 8'h3C), 1,
                quiet_answer(8'h3C, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, DIP_A_ADDR, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'hFF, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, DIP_B_ADDR, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'hFF, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, 16'hC005, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(OPEN_BUS, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(OPEN_BUS, 1'b0, 17'h0, 2'd0));
        // The RAMs must read as zero once the sweep after reset is over.
        add_row(bus_req(REQ_READ, 16'hCC7F, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, 16'hDBFF, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b0, 17'h0, 2'd0));
        add_row(bus_req(REQ_READ, 16'hEFFF, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b0, 17'h0, 2'd0));
        // Top bank with the top banked address gives the largest ROM offset.
        add_row(bus_req(REQ_WRITE, BANK_ADDR, 8'hFF, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b0, 17'h0, 2'd3));
        add_row(bus_req(REQ_READ, 16'hBFFF, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                quiet_answer(8'h00, 1'b1, 17'h17FFF, 2'd3));
        // A sound reset write without bit 4 leaves the request alone, one with
        // bit 4 sets it, and a frame start clears it again.
        add_row(bus_req(REQ_WRITE, SRESET_ADDR, 8'hEF, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, SRESET_ADDR, 8'h10, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_FRAME, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, SOUND_ADDR, 8'hFF, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, SCROLL_LO_ADDR, 8'h34, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, SCROLL_HI_ADDR, 8'hFF, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, PALETTE_ADDR, 8'hFE, 8'h00, 8'h00, 8'h00), 0, '0);
        // Last sprite byte, then the first address past the sprite RAM.
        add_row(bus_req(REQ_WRITE, 16'hCC7F, 8'hA5, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_READ, 16'hCC7F, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, SPRITE_END, 8'h5A, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_READ, SPRITE_END, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
        // The unused request code and a write into ROM change nothing.
        add_row(bus_req(REQ_UNUSED, BANK_ADDR, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(bus_req(REQ_WRITE, 16'h1234, 8'h77, 8'h00, 8'h00, 8'h00), 0, '0);

        directed_count = stim_table.size();
        foreach (stim_table[i])
            issue(stim_table[i].rq, stim_table[i].pinned, stim_table[i].want, 0);
        start <= 1'b0;

        // Random traffic in four pacing phases, with the switch banks moved to
        // new settings (extremes first) while the decoder is idle.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_register(CFG_DIP_A, 8'h00);
                    write_register(CFG_DIP_B, 8'hFF);
                end
                1:
                begin
                    write_register(CFG_DIP_A, 8'hFF);
                    write_register(CFG_DIP_B, 8'h00);
                end
                default:
                begin
                    write_register(CFG_DIP_A, 8'($urandom_range(0, 255)));
                    write_register(CFG_DIP_B, 8'($urandom_range(0, 255)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(random_access(), 0, '0, idle_by_phase[ph]);
            start <= 1'b0;
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Bus decoder run: %0d transactions (%0d directed), %0d results checked,",
                 accesses_taken, directed_count, answers_checked);
        $display("four pacing phases with DIP banks at both extremes, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && due_answers.size() == 0)
            $display("** arcade_main_bus_decoder_core: PASSED **");
        else
            $display("** arcade_main_bus_decoder_core: FAILED **");
        $finish;
    end

endmodule
